// ===== hdl/hcc_pkg.sv =====
// Shared constants and modulo-26 helper functions for the Hill cipher codec.
`default_nettype none
package hcc_pkg;

    localparam int LETTER_W  = 5;
    localparam int KEY_ROW_W = 15;
    localparam int CFG_IDX_W = 3;
    localparam int SUM_W     = 11;

    localparam logic [LETTER_W-1:0] MODULUS    = 5'd26;
    localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW2   = 3'd4;

    localparam logic [1:0] BLOCK_SIZE_3 = 2'd3;

    typedef logic [LETTER_W-1:0]  t_letter;
    typedef logic [KEY_ROW_W-1:0] t_key_row;
    typedef logic [SUM_W-1:0]     t_sum;

    // Reduce a 5-bit value (0..31) into 0..25.
    function automatic t_letter red26(input t_letter x);
        red26 = (x >= MODULUS) ? x - MODULUS : x;
    endfunction

    // Additive inverse of a value already in 0..25.
    function automatic t_letter neg26(input t_letter x);
        neg26 = (x == '0) ? '0 : MODULUS - x;
    endfunction

    // Reciprocal multiply by 78/2048 underestimates the quotient by at most one.
    function automatic t_letter mod26(input t_sum v);
        logic [17:0] p;
        logic [6:0]  q;
        logic [11:0] r;
        p = 18'(v) * 18'd78;
        q = p[17:11];
        r = 12'(v) - 12'(q) * 12'd26;
        if (r >= 12'd26) begin
            r = r - 12'd26;
        end
        mod26 = r[LETTER_W-1:0];
    endfunction

    // Multiplicative inverse modulo 26, zero where none exists.
    function automatic t_letter inv26(input t_letter x);
        case (x)
            5'd1:    inv26 = 5'd1;
            5'd3:    inv26 = 5'd9;
            5'd5:    inv26 = 5'd21;
            5'd7:    inv26 = 5'd15;
            5'd9:    inv26 = 5'd3;
            5'd11:   inv26 = 5'd19;
            5'd15:   inv26 = 5'd7;
            5'd17:   inv26 = 5'd23;
            5'd19:   inv26 = 5'd11;
            5'd21:   inv26 = 5'd5;
            5'd23:   inv26 = 5'd17;
            5'd25:   inv26 = 5'd25;
            default: inv26 = 5'd0;
        endcase
    endfunction

    // Pick the 5-bit entry of column col from a key row.
    function automatic t_letter key_field(input t_key_row row, input logic [1:0] col);
        case (col)
            2'd0:    key_field = row[4:0];
            2'd1:    key_field = row[9:5];
            default: key_field = row[14:10];
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== hdl/hcc_in_if.sv =====
// Input letter channel: valid/ready handshake with letter payload.
`default_nettype none
interface hcc_in_if;
    import hcc_pkg::*;

    logic    valid;
    logic    ready;
    t_letter letter;
    logic    end_of_message;

    modport source (output valid, output letter, output end_of_message, input ready);
    modport sink   (input valid, input letter, input end_of_message, output ready);
endinterface
`default_nettype wire

// ===== hdl/hcc_out_if.sv =====
// Output letter channel: valid/ready handshake with result payload.
`default_nettype none
interface hcc_out_if;
    import hcc_pkg::*;

    logic    valid;
    logic    ready;
    t_letter out_letter;
    logic    last_of_block;
    logic    last_of_message;
    logic    key_error;

    modport source (output valid, output out_letter, output last_of_block,
                    output last_of_message, output key_error, input ready);
    modport sink   (input valid, input out_letter, input last_of_block,
                    input last_of_message, input key_error, output ready);
endinterface
`default_nettype wire

// ===== hdl/hill_cipher_block_codec.sv =====
// Hill cipher mod-26 block codec with one shared multiply-accumulate unit.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------------------
//  i_in     | in  | valid/ready   | letter, end_of_message
//  o_out    | out | valid/ready   | out_letter, last_of_block, last_of_message, key_error
//  i_cfg_*  | in  | write enable  | register index, 15-bit data
//
// A letter is taken whenever the codec is idle; ready is low while a block is worked on.
// Each result letter is accumulated in ST_MAC over the n letters of the block (n = block
// size), then passes ST_SCALE in decrypt and ST_RED, and sits in the output register until
// transferred. A 2x2 decrypt block first passes ST_DET1, ST_DET2 and ST_CHECK for
// determinant and inverse; key errors skip the MACs. All steps share the 5x5 multiplier and mod-26 reducer.
// Reset is synchronous; it restores the identity key, encrypt, block size 2.
`default_nettype none
module hill_cipher_block_codec #(
    parameter int MAX_BLOCK = 3
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    hcc_in_if.sink                          i_in,
    hcc_out_if.source                       o_out,
    input  wire                             i_cfg_we,
    input  wire [hcc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [hcc_pkg::KEY_ROW_W-1:0]    i_cfg_data
);
    import hcc_pkg::*;

    localparam int IW = $clog2(MAX_BLOCK);
    localparam int FW = $clog2(MAX_BLOCK + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DET1,
        ST_DET2,
        ST_CHECK,
        ST_MAC,
        ST_SCALE,
        ST_RED,
        ST_OUT
    } t_state;

    t_state         r_state;
    logic           r_mode;
    logic [1:0]     r_bs;
    t_key_row       r_key [3];
    t_letter        r_buf [MAX_BLOCK];
    logic [FW-1:0]  r_fill;
    logic [IW-1:0]  r_k;
    logic [IW-1:0]  r_j;
    t_sum           r_sum;
    t_letter        r_inv;
    logic           r_err;
    logic           r_eom;
    logic           r_out_valid;
    t_letter        r_out_letter;
    logic           r_out_lob;
    logic           r_out_lom;
    logic           r_out_err;

    logic [FW-1:0]  blk_n;
    logic [FW-1:0]  blk_last;
    logic [FW-1:0]  f0;
    logic [FW-1:0]  f1;
    logic           in_xfer;
    logic           k_last;
    logic           j_last;
    logic [1:0]     kk;
    logic [1:0]     jj;
    t_letter        ka, kb, kc, kd;
    t_letter        sum_red;
    t_letter        adj;
    t_letter        op_x;
    t_letter        op_y;
    t_sum           op_base;
    logic [9:0]     prod;
    t_sum           sum_nxt;
    t_letter        inv_val;

    assign blk_n    = (r_bs == BLOCK_SIZE_3 && MAX_BLOCK >= 3) ? FW'(3) : FW'(2);
    assign blk_last = blk_n - FW'(1);
    assign f0       = (r_fill >= blk_n) ? '0 : r_fill;
    assign f1       = f0 + FW'(1);
    assign in_xfer  = i_in.valid && i_in.ready;
    assign k_last   = (FW'(r_k) == blk_last);
    assign j_last   = (FW'(r_j) == blk_last);
    assign kk       = 2'(r_k);
    assign jj       = 2'(r_j);

    assign i_in.ready            = (r_state == ST_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.out_letter      = r_out_letter;
    assign o_out.last_of_block   = r_out_lob;
    assign o_out.last_of_message = r_out_lom;
    assign o_out.key_error       = r_out_err;

    assign ka      = red26(key_field(r_key[0], 2'd0));
    assign kb      = red26(key_field(r_key[0], 2'd1));
    assign kc      = red26(key_field(r_key[1], 2'd0));
    assign kd      = red26(key_field(r_key[1], 2'd1));
    assign sum_red = mod26(r_sum);
    assign inv_val = inv26(sum_red);

    // Adjugate of the 2x2 key; the determinant inverse is applied afterwards.
    always_comb begin
        case ({kk[0], jj[0]})
            2'b00:   adj = kd;
            2'b01:   adj = neg26(kb);
            2'b10:   adj = neg26(kc);
            default: adj = ka;
        endcase
    end

    always_comb begin
        op_x    = '0;
        op_y    = '0;
        op_base = '0;
        case (r_state)
            ST_DET1: begin
                op_x = kb;
                op_y = kc;
            end
            ST_DET2: begin
                op_x    = ka;
                op_y    = kd;
                op_base = SUM_W'(neg26(sum_red));
            end
            ST_MAC: begin
                op_x    = r_buf[r_k];
                op_y    = r_mode ? adj : key_field(r_key[kk], jj);
                op_base = r_sum;
            end
            ST_SCALE: begin
                op_x = sum_red;
                op_y = r_inv;
            end
            default: begin
                op_x = '0;
            end
        endcase
    end

    assign prod    = 10'(red26(op_x)) * 10'(red26(op_y));
    assign sum_nxt = op_base + SUM_W'(prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_bs     <= 2'd2;
            r_key[0] <= 15'd1;
            r_key[1] <= 15'd32;
            r_key[2] <= 15'd1024;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:       r_mode   <= i_cfg_data[0];
                CFG_BLOCK_SIZE: r_bs     <= i_cfg_data[1:0];
                CFG_KEY_ROW0:   r_key[0] <= i_cfg_data;
                CFG_KEY_ROW1:   r_key[1] <= i_cfg_data;
                CFG_KEY_ROW2:   r_key[2] <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        for (int i = 0; i < MAX_BLOCK; i++) begin
                            if (FW'(i) == f0) begin
                                r_buf[i] <= i_in.letter;
                            end else if (FW'(i) > f0 && FW'(i) < blk_n
                                         && i_in.end_of_message && !r_mode) begin
                                r_buf[i] <= PAD_LETTER;
                            end
                        end
                        r_k   <= '0;
                        r_j   <= '0;
                        r_sum <= '0;
                        r_eom <= i_in.end_of_message;
                        r_err <= r_mode && (blk_n != FW'(2));
                        if (f1 < blk_n && !i_in.end_of_message) begin
                            r_fill <= f1;
                        end else if (f1 < blk_n && r_mode) begin
                            r_fill <= '0;
                        end else begin
                            r_fill <= '0;
                            if (!r_mode) begin
                                r_state <= ST_MAC;
                            end else if (blk_n != FW'(2)) begin
                                r_state <= ST_RED;
                            end else begin
                                r_state <= ST_DET1;
                            end
                        end
                    end
                end
                ST_DET1: begin
                    r_sum   <= sum_nxt;
                    r_state <= ST_DET2;
                end
                ST_DET2: begin
                    r_sum   <= sum_nxt;
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    r_inv <= inv_val;
                    r_sum <= '0;
                    if (inv_val == '0) begin
                        r_err   <= 1'b1;
                        r_state <= ST_RED;
                    end else begin
                        r_state <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    r_sum <= sum_nxt;
                    r_k   <= r_k + IW'(1);
                    if (k_last) begin
                        r_state <= r_mode ? ST_SCALE : ST_RED;
                    end
                end
                ST_SCALE: begin
                    r_sum   <= sum_nxt;
                    r_state <= ST_RED;
                end
                ST_RED: begin
                    r_out_letter <= r_err ? '0 : sum_red;
                    r_out_lob    <= j_last;
                    r_out_lom    <= j_last && r_eom;
                    r_out_err    <= r_err;
                    r_out_valid  <= 1'b1;
                    r_state      <= ST_OUT;
                end
                ST_OUT: begin
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                        r_k         <= '0;
                        r_sum       <= '0;
                        if (j_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_j     <= r_j + IW'(1);
                            r_state <= r_err ? ST_RED : ST_MAC;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== tb/tb_hill_cipher_block_codec.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Hill cipher block codec: directed cases, back-pressure, random streams.
module tb_hill_cipher_block_codec;
    import hcc_pkg::*;

    localparam int LETTER_MOD    = 26;
    localparam int SETTLE_CYCLES = 40;

    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    localparam logic [1:0] BLOCK_SIZE_0 = 2'd0;
    localparam logic [1:0] BLOCK_SIZE_1 = 2'd1;
    localparam logic [1:0] BLOCK_SIZE_2 = 2'd2;

    typedef struct packed {
        t_letter out_letter;
        logic    last_of_block;
        logic    last_of_message;
        logic    key_error;
    } t_cipher_letter;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    t_key_row             cfg_data;

    hcc_in_if  in_ch ();
    hcc_out_if out_ch ();

    hill_cipher_block_codec u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // codec state as predicted
    logic       cfg_mode;
    logic [1:0] cfg_block_size;
    t_key_row   key_rows [3];
    t_letter    held_letters [3];
    int         held_count;

    t_cipher_letter cipher_out_q [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int letters_in     = 0;
    int letters_out    = 0;
    int key_err_out    = 0;
    int cfg_writes     = 0;
    int mismatches     = 0;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #(10_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic t_key_row key_row_of(input int c0, input int c1, input int c2);
        return t_key_row'(c0) | (t_key_row'(c1) << 5) | (t_key_row'(c2) << 10);
    endfunction

    function automatic int key_digit(input int r, input int c);
        return int'((key_rows[r] >> (5 * c)) & 15'h1f) % LETTER_MOD;
    endfunction

    // inverse of the 2x2 determinant mod 26, zero when none exists
    function automatic int det_inverse(input t_key_row row0, input t_key_row row1);
        int a, b, c, d, det, inv;
        a = int'(row0[4:0]) % LETTER_MOD;
        b = int'(row0[9:5]) % LETTER_MOD;
        c = int'(row1[4:0]) % LETTER_MOD;
        d = int'(row1[9:5]) % LETTER_MOD;
        det = (a * d - b * c) % LETTER_MOD;
        if (det < 0) begin
            det += LETTER_MOD;
        end
        inv = 0;
        for (int t = 1; t < LETTER_MOD; t++) begin
            if (inv == 0 && (det * t) % LETTER_MOD == 1) begin
                inv = t;
            end
        end
        return inv;
    endfunction

    task automatic codec_step(input t_letter ltr, input logic eom);
        int n, a, b, c, d, inv, acc;
        int km [3][3];
        logic err;
        t_cipher_letter r;
        n = (cfg_block_size == BLOCK_SIZE_3) ? 3 : 2;
        if (held_count >= n) begin
            held_count = 0;
        end
        held_letters[held_count] = ltr;
        held_count++;
        if (held_count < n) begin
            if (!eom) begin
                return;
            end
            if (cfg_mode == MODE_DECRYPT) begin
                held_count = 0;
                return;
            end
            for (int i = held_count; i < n; i++) begin
                held_letters[i] = PAD_LETTER;
            end
        end
        held_count = 0;
        err = 1'b0;
        foreach (km[i, j]) begin
            km[i][j] = 0;
        end
        if (cfg_mode == MODE_ENCRYPT) begin
            for (int i = 0; i < n; i++) begin
                for (int j = 0; j < n; j++) begin
                    km[i][j] = key_digit(i, j);
                end
            end
        end else if (n != 2) begin
            err = 1'b1;
        end else begin
            inv = det_inverse(key_rows[0], key_rows[1]);
            if (inv == 0) begin
                err = 1'b1;
            end else begin
                a = key_digit(0, 0);
                b = key_digit(0, 1);
                c = key_digit(1, 0);
                d = key_digit(1, 1);
                km[0][0] = (d * inv) % LETTER_MOD;
                km[0][1] = (((LETTER_MOD - b) % LETTER_MOD) * inv) % LETTER_MOD;
                km[1][0] = (((LETTER_MOD - c) % LETTER_MOD) * inv) % LETTER_MOD;
                km[1][1] = (a * inv) % LETTER_MOD;
            end
        end
        for (int j = 0; j < n; j++) begin
            acc = 0;
            if (!err) begin
                for (int k = 0; k < n; k++) begin
                    acc = (acc + (int'(held_letters[k]) % LETTER_MOD) * km[k][j]) % LETTER_MOD;
                end
            end
            r.out_letter      = t_letter'(acc);
            r.last_of_block   = (j == n - 1);
            r.last_of_message = (j == n - 1) && eom;
            r.key_error       = err;
            cipher_out_q.push_back(r);
        end
    endtask

    task automatic send_letter(input t_letter ltr, input logic eom);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.letter         <= ltr;
        in_ch.end_of_message <= eom;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        codec_step(ltr, eom);
        letters_in++;
    endtask

    // sender stops until every predicted letter has come out
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (cipher_out_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input t_key_row data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_MODE:       cfg_mode       = data[0];
            CFG_BLOCK_SIZE: cfg_block_size = data[1:0];
            CFG_KEY_ROW0:   key_rows[0]    = data;
            CFG_KEY_ROW1:   key_rows[1]    = data;
            CFG_KEY_ROW2:   key_rows[2]    = data;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_codec(input logic mode, input logic [1:0] bsize,
                             input t_key_row k0, input t_key_row k1, input t_key_row k2);
        drain();
        cfg_write(CFG_MODE, t_key_row'(mode));
        cfg_write(CFG_BLOCK_SIZE, t_key_row'(bsize));
        cfg_write(CFG_KEY_ROW0, k0);
        cfg_write(CFG_KEY_ROW1, k1);
        cfg_write(CFG_KEY_ROW2, k2);
    endtask

    function automatic t_letter rand_letter();
        if ($urandom_range(0, 11) == 0) begin
            return t_letter'($urandom_range(26, 31));
        end
        return t_letter'($urandom_range(0, 25));
    endfunction

    function automatic t_key_row rand_key_row();
        int pick;
        int e [3];
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            return '0;
        end
        if (pick < 10) begin
            return 15'h7fff;
        end
        foreach (e[c]) begin
            e[c] = ($urandom_range(0, 9) == 0) ? $urandom_range(26, 31) : $urandom_range(0, 25);
        end
        return key_row_of(e[0], e[1], e[2]);
    endfunction

    task automatic random_config();
        logic       mode;
        logic [1:0] bsize;
        t_key_row   k0, k1, k2;
        mode  = logic'($urandom_range(0, 1));
        bsize = 2'($urandom_range(0, 3));
        k0    = rand_key_row();
        k1    = rand_key_row();
        k2    = rand_key_row();
        if (mode == MODE_DECRYPT) begin
            if (bsize == BLOCK_SIZE_3 && $urandom_range(0, 3) != 0) begin
                bsize = 2'($urandom_range(0, 2));
            end
            if ($urandom_range(0, 99) < 80) begin
                while (det_inverse(k0, k1) == 0) begin
                    k0 = rand_key_row();
                    k1 = rand_key_row();
                end
            end
        end
        set_codec(mode, bsize, k0, k1, k2);
    endtask

    // receiver: random stalls plus an optional long hold-off counted here
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        t_cipher_letter want;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            letters_out++;
            if (out_ch.key_error === 1'b1) begin
                key_err_out++;
            end
            if (cipher_out_q.size() == 0) begin
                $error("unexpected transfer: out_letter %0d", out_ch.out_letter);
                mismatches++;
            end else begin
                want = cipher_out_q.pop_front();
                if (out_ch.out_letter !== want.out_letter) begin
                    $error("out_letter: expected %0d, actual %0d",
                           want.out_letter, out_ch.out_letter);
                    mismatches++;
                end
                if (out_ch.last_of_block !== want.last_of_block) begin
                    $error("last_of_block: expected %0b, actual %0b",
                           want.last_of_block, out_ch.last_of_block);
                    mismatches++;
                end
                if (out_ch.last_of_message !== want.last_of_message) begin
                    $error("last_of_message: expected %0b, actual %0b",
                           want.last_of_message, out_ch.last_of_message);
                    mismatches++;
                end
                if (out_ch.key_error !== want.key_error) begin
                    $error("key_error: expected %0b, actual %0b",
                           want.key_error, out_ch.key_error);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_reset_state();
        send_letter(5'd0, 1'b0);
        send_letter(5'd25, 1'b0);
        send_letter(5'd31, 1'b0);
        send_letter(5'd26, 1'b1);
    endtask

    task automatic test_encrypt_2x2();
        set_codec(MODE_ENCRYPT, BLOCK_SIZE_2, key_row_of(3, 3, 0), key_row_of(2, 5, 0), 15'h7fff);
        send_letter(5'd7, 1'b0);
        send_letter(5'd4, 1'b0);
        send_letter(5'd11, 1'b1);
    endtask

    task automatic test_encrypt_3x3();
        set_codec(MODE_ENCRYPT, BLOCK_SIZE_3, key_row_of(6, 24, 1), key_row_of(13, 16, 10),
                  key_row_of(20, 17, 15));
        send_letter(5'd0, 1'b0);
        send_letter(5'd2, 1'b0);
        send_letter(5'd19, 1'b1);
        send_letter(5'd1, 1'b1);
    endtask

    task automatic test_decrypt_2x2();
        set_codec(MODE_DECRYPT, BLOCK_SIZE_2, key_row_of(3, 3, 0), key_row_of(2, 5, 0), '0);
        send_letter(5'd7, 1'b0);
        send_letter(5'd8, 1'b0);
        send_letter(5'd5, 1'b1);
    endtask

    task automatic test_key_errors();
        // even determinant, determinant 13, then any 3x3 decrypt
        set_codec(MODE_DECRYPT, BLOCK_SIZE_2, key_row_of(2, 4, 0), key_row_of(1, 3, 0), '0);
        send_letter(5'd1, 1'b0);
        send_letter(5'd2, 1'b1);
        set_codec(MODE_DECRYPT, BLOCK_SIZE_2, key_row_of(1, 0, 0), key_row_of(0, 13, 0), '0);
        send_letter(5'd9, 1'b0);
        send_letter(5'd30, 1'b1);
        set_codec(MODE_DECRYPT, BLOCK_SIZE_3, key_row_of(6, 24, 1), key_row_of(13, 16, 10),
                  key_row_of(20, 17, 15));
        send_letter(5'd4, 1'b0);
        send_letter(5'd5, 1'b0);
        send_letter(5'd6, 1'b1);
    endtask

    task automatic test_block_size_codes();
        set_codec(MODE_ENCRYPT, BLOCK_SIZE_0, key_row_of(31, 26, 0), key_row_of(5, 29, 0), '0);
        send_letter(5'd3, 1'b0);
        send_letter(5'd17, 1'b0);
        set_codec(MODE_ENCRYPT, BLOCK_SIZE_3, key_row_of(6, 24, 1), key_row_of(13, 16, 10),
                  key_row_of(20, 17, 15));
        send_letter(5'd12, 1'b0);
        send_letter(5'd14, 1'b0);
        // size lowered with two letters held: they are thrown away
        set_codec(MODE_ENCRYPT, BLOCK_SIZE_1, key_row_of(31, 26, 0), key_row_of(5, 29, 0), '0);
        send_letter(5'd21, 1'b1);
    endtask

    task automatic test_backpressure();
        set_codec(MODE_ENCRYPT, BLOCK_SIZE_3, key_row_of(6, 24, 1), key_row_of(13, 16, 10),
                  key_row_of(20, 17, 15));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 300;
        for (int i = 0; i < 15; i++) begin
            send_letter(rand_letter(), i == 14);
        end
        drain();
        for (int i = 0; i < 6; i++) begin
            send_letter(rand_letter(), i == 5);
        end
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
        int target, len;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = letters_in + count;
        while (letters_in < target) begin
            if ($urandom_range(0, 3) == 0) begin
                random_config();
            end
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++) begin
                send_letter(rand_letter(), (i == len - 1) || ($urandom_range(0, 19) == 0));
            end
        end
    endtask

    initial begin
        in_ch.valid          = 1'b0;
        in_ch.letter         = '0;
        in_ch.end_of_message = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = '0;
        cfg_data             = '0;
        rst_n                = 1'b0;
        cfg_mode             = MODE_ENCRYPT;
        cfg_block_size       = BLOCK_SIZE_2;
        key_rows             = '{15'd1, 15'd32, 15'd1024};
        held_letters         = '{default: '0};
        held_count           = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_encrypt_2x2();
        test_encrypt_3x3();
        test_decrypt_2x2();
        test_key_errors();
        test_block_size_codes();
        test_backpressure();
        test_random_phase(0, 0, 105);
        test_random_phase(50, 0, 105);
        test_random_phase(0, 50, 105);
        test_random_phase(26, 26, 105);
        drain();

        $display("Run covered %0d letters in and %0d letters out (%0d flagged key_error),",
                 letters_in, letters_out, key_err_out);
        $display("over %0d register writes in both modes and all block size codes.", cfg_writes);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/hcc_pkg.sv
hdl/hcc_in_if.sv
hdl/hcc_out_if.sv
hdl/hill_cipher_block_codec.sv
tb/tb_hill_cipher_block_codec.sv
